// ===== src/thd_pkg.sv =====
// Shared types and constants for the triad halfstrip decoder.
// No dependencies; used by thd_lane, thd_merge and triad_halfstrip_decoder_unit.
`default_nettype none

package thd_pkg;

    localparam int DISTRIPS_DEF     = 8;
    localparam int MAX_BUCKETS_DEF  = 32;
    localparam int HS_PER_LANE      = 4;   // 2 * strip + halfstrip per distrip
    localparam int HITS_W           = 32;
    localparam int START_W          = 5;
    localparam int BIDX_W           = 6;
    localparam int CFG_W            = 6;

    localparam logic [BIDX_W-1:0] BIDX_SAT        = 6'd63;
    localparam logic [CFG_W-1:0]  BUCKET_COUNT_RST = 6'd16;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_STRIP = 2'd1,
        PH_HALF  = 2'd2
    } lane_phase_t;

    // Per-beat control fanned out to every lane.
    typedef struct packed {
        logic step;      // a beat is accepted this cycle
        logic clear;     // new event: lanes restart before this beat
        logic start_ok;  // a triad may still start in this bucket
    } lane_ctrl_t;

endpackage : thd_pkg

`default_nettype wire

// ===== src/thd_lane.sv =====
// One distrip lane: tracks the triad phase and decodes a halfstrip hit.
// Depends on thd_pkg.
`default_nettype none

module thd_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire thd_pkg::lane_ctrl_t ctrl,
    input  wire logic               bit_in,
    output logic [thd_pkg::HS_PER_LANE-1:0] hit
);
    import thd_pkg::*;

    lane_phase_t phase_reg, phase_next, phase_cur;
    logic        strip_reg, strip_next, strip_cur;

    // new event wipes the lane before this bucket is looked at
    assign phase_cur = ctrl.clear ? PH_IDLE : phase_reg;
    assign strip_cur = ctrl.clear ? 1'b0 : strip_reg;

    // next state
    always_comb
    begin
        phase_next = phase_cur;
        strip_next = strip_cur;
        unique case (phase_cur)
            PH_IDLE:
            begin
                if (bit_in && ctrl.start_ok)
                begin
                    phase_next = PH_STRIP;
                end
            end
            PH_STRIP:
            begin
                strip_next = bit_in;
                phase_next = PH_HALF;
            end
            PH_HALF:
            begin
                strip_next = 1'b0;
                phase_next = PH_IDLE;
            end
            default:
            begin
                strip_next = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // outputs: one-hot halfstrip within this distrip
    always_comb
    begin
        hit = '0;
        unique case (phase_cur)
            PH_HALF:
            begin
                hit[{strip_cur, bit_in}] = 1'b1;
            end
            default:
            begin
                hit = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            strip_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            phase_reg <= phase_next;
            strip_reg <= strip_next;
        end
    end

endmodule : thd_lane

`default_nettype wire

// ===== src/thd_merge.sv =====
// Merges lane hits into the 32-bit halfstrip vector and derives the start bucket.
// Depends on thd_pkg.
`default_nettype none

module thd_merge #(
    parameter int DISTRIPS = thd_pkg::DISTRIPS_DEF
) (
    input  wire logic [DISTRIPS*thd_pkg::HS_PER_LANE-1:0] lane_hits,
    input  wire logic [thd_pkg::BIDX_W-1:0]              cur_bucket,
    output logic [thd_pkg::HITS_W-1:0]                   hits,
    output logic [thd_pkg::START_W-1:0]                  start_bucket
);
    import thd_pkg::*;

    localparam int LANE_BITS = DISTRIPS * HS_PER_LANE;

    logic [BIDX_W-1:0] start_full;

    // halfstrips past the output width are dropped
    genvar k;
    generate
        for (k = 0; k < HITS_W; k++)
        begin : g_hit
            if (k < LANE_BITS)
            begin : g_used
                assign hits[k] = lane_hits[k];
            end
            else
            begin : g_none
                assign hits[k] = 1'b0;
            end
        end
    endgenerate

    // triads complete two buckets after they start
    assign start_full   = cur_bucket - BIDX_W'(2);
    assign start_bucket = (hits != '0) ? start_full[START_W-1:0] : '0;

endmodule : thd_merge

`default_nettype wire

// ===== src/triad_halfstrip_decoder_unit.sv =====
// Top level of the triad halfstrip decoder: lanes, merge, bucket counter, output skid.
// Depends on thd_pkg, thd_lane and thd_merge.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per time bucket, carrying
//   new_event and bucket_bits (bit d = serial bit of distrip d). Raise
//   new_event on the first bucket of each readout.
//   Output channel (out_valid/out_ready): one beat per input beat, with
//   halfstrip_hits for triads that finished in that bucket and start_bucket
//   (bucket of the triad's first bit; 0 when no hit).
//   Config: cfg_we/cfg_wdata write bucket_count; write only
//   while idle. Values above MAX_BUCKETS act as MAX_BUCKETS.
//   Result: registered into the output register, or the skid entry under stall.
//   Throughput: one beat per cycle while in_ready is high; every lane works on
//   its distrip in the same cycle; the merge is a plain OR-map, so nothing iterates.
//   Stall: a two-entry output (register plus skid) absorbs one extra beat;
//   in_ready drops only while the skid entry is full.
//   Reset: lanes idle, bucket counter zero, bucket_count = 16, output empty.
`default_nettype none

module triad_halfstrip_decoder_unit #(
    parameter int DISTRIPS    = thd_pkg::DISTRIPS_DEF,
    parameter int MAX_BUCKETS = thd_pkg::MAX_BUCKETS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // config
    input  wire logic                         cfg_we,
    input  wire logic [thd_pkg::CFG_W-1:0]    cfg_wdata,
    // input beats
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         new_event,
    input  wire logic [DISTRIPS-1:0]          bucket_bits,
    // output beats
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [thd_pkg::HITS_W-1:0]        halfstrip_hits,
    output logic [thd_pkg::START_W-1:0]       start_bucket
);
    import thd_pkg::*;

    localparam logic [CFG_W-1:0] MAX_B = CFG_W'(MAX_BUCKETS);

    logic [CFG_W-1:0]  bucket_count_reg;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [BIDX_W-1:0] cur_bucket;
    logic [CFG_W-1:0]  eff_count;
    logic              accept;
    lane_ctrl_t        ctrl;

    logic [DISTRIPS*HS_PER_LANE-1:0] lane_hits;
    logic [HITS_W-1:0]  hits_new;
    logic [START_W-1:0] start_new;

    // output register plus skid entry
    logic               out_valid_reg, skid_valid_reg;
    logic [HITS_W-1:0]  out_hits_reg, skid_hits_reg;
    logic [START_W-1:0] out_start_reg, skid_start_reg;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
        end
        else if (cfg_we)
        begin
            bucket_count_reg <= cfg_wdata;
        end
    end

    assign eff_count  = (bucket_count_reg > MAX_B) ? MAX_B : bucket_count_reg;
    assign cur_bucket = new_event ? '0 : bidx_reg;

    // late-start rule: bucket + 2 < effective count
    assign ctrl.step     = accept;
    assign ctrl.clear    = new_event;
    assign ctrl.start_ok = ({1'b0, cur_bucket} + (BIDX_W+1)'(2)) < {1'b0, eff_count};

    // bucket counter saturates
    assign bidx_next = (cur_bucket < BIDX_SAT) ? cur_bucket + BIDX_W'(1) : cur_bucket;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bidx_reg <= '0;
        end
        else if (accept)
        begin
            bidx_reg <= bidx_next;
        end
    end

    genvar d;
    generate
        for (d = 0; d < DISTRIPS; d++)
        begin : g_lane
            thd_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .bit_in (bucket_bits[d]),
                .hit    (lane_hits[d*HS_PER_LANE +: HS_PER_LANE])
            );
        end
    endgenerate

    thd_merge #(
        .DISTRIPS (DISTRIPS)
    ) u_merge (
        .lane_hits    (lane_hits),
        .cur_bucket   (cur_bucket),
        .hits         (hits_new),
        .start_bucket (start_new)
    );

    // output side: main register drains first, skid catches a beat under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_hits_reg  <= skid_hits_reg;
                out_start_reg <= skid_start_reg;
            end
            else if (accept)
            begin
                out_hits_reg  <= hits_new;
                out_start_reg <= start_new;
            end
        end
        else if (accept)
        begin
            skid_hits_reg  <= hits_new;
            skid_start_reg <= start_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign halfstrip_hits = out_hits_reg;
    assign start_bucket   = out_start_reg;

`ifndef SYNTHESIS
    // skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // no hits means start bucket reads zero
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (halfstrip_hits == '0)) |-> (start_bucket == '0))
        else $error("start_bucket nonzero without hits");

    // new event restarts the bucket count
    a_new_event_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && new_event) |=> (bidx_reg == BIDX_W'(1)))
        else $error("bucket counter not restarted on new event");
`endif

endmodule : triad_halfstrip_decoder_unit

`default_nettype wire
